FILE: rtl/core/hrfq_pkg.sv
`default_nettype none

package hrfq_pkg;

    // Buffer and counter geometry.
    localparam int BUF_DEPTH     = 4096;
    localparam int COUNTER_WIDTH = 16;

    // Fixed widths of the port fields.
    localparam int CFG_W     = 13;
    localparam int ADDR_W    = 12;
    localparam int TOTAL_W   = 16;
    localparam int STATE_W   = 3;

    // Byte count must hold the buffer depth itself.
    localparam int CNT_W = $clog2(BUF_DEPTH) + 1;
    // Width used for count and limit arithmetic.
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Frame rules.
    localparam logic [LIM_W-1:0] MIN_FRAME = LIM_W'(10);
    localparam logic [LIM_W-1:0] CRC_BYTES = LIM_W'(2);

    // Register reset value and the limit it gives.
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);
    localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(BUF_DEPTH);
    localparam logic [LIM_W-1:0] LIM_RESET =
        (LIM_W'(CFG_RESET) < DEPTH_LIM) ? LIM_W'(CFG_RESET) : DEPTH_LIM;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_STATUS  = 2'd1,
        OP_TX_MODE = 2'd2,
        OP_RX_MODE = 2'd3
    } op_t;

    typedef enum logic [STATE_W-1:0] {
        RX_IDLE     = 3'd0,
        RX_ACTIVE   = 3'd1,
        RX_ERROR    = 3'd2,
        RX_ABORT    = 3'd3,
        RX_OVERSIZE = 3'd4
    } rx_state_t;

    typedef struct packed {
        logic [1:0] operation;
        logic       char_available;
        logic       overrun;
        logic [7:0] data_byte;
        logic       end_of_frame;
        logic       crc_bad;
        logic       abort_seen;
    } in_word_t;

    typedef struct packed {
        logic               store_valid;
        logic [ADDR_W-1:0]  store_address;
        logic [7:0]         store_byte;
        logic               frame_commit;
        logic [ADDR_W-1:0]  frame_length;
        logic               frame_drop;
        logic [TOTAL_W-1:0] crc_error_total;
        logic [TOTAL_W-1:0] overrun_total;
        logic [TOTAL_W-1:0] oversize_total;
        logic [TOTAL_W-1:0] abort_total;
        logic [TOTAL_W-1:0] end_total;
        logic [STATE_W-1:0] receive_state;
    } out_word_t;

    // Classified command handed from front to back.
    typedef struct packed {
        op_t        op;
        logic       has_char;
        logic       overrun;
        logic [7:0] data_byte;
        logic       eof;
        logic       crc_bad;
        logic       abort_req;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/hrfq_front.sv
`default_nettype none

module hrfq_front (
    input  wire              in_valid,
    output logic             in_stall,
    input  hrfq_pkg::in_word_t in_word,
    output logic             push,
    output hrfq_pkg::cmd_t   cmd,
    input  wire              queue_full
);
    import hrfq_pkg::*;

    // Take a word whenever the queue has room.
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // Decode the operation and keep only the flags that matter for it.
    always_comb
    begin
        cmd.op        = op_t'(in_word.operation);
        cmd.data_byte = in_word.data_byte;
        cmd.has_char  = 1'b0;
        cmd.overrun   = 1'b0;
        cmd.eof       = 1'b0;
        cmd.crc_bad   = 1'b0;
        cmd.abort_req = 1'b0;
        unique case (cmd.op)
            OP_RECEIVE:
            begin
                cmd.has_char = in_word.char_available;
                cmd.overrun  = in_word.char_available && in_word.overrun;
                cmd.eof      = in_word.end_of_frame;
                cmd.crc_bad  = in_word.end_of_frame && in_word.crc_bad;
            end
            OP_STATUS:
            begin
                cmd.abort_req = in_word.abort_seen;
            end
            OP_TX_MODE, OP_RX_MODE:
            begin
                cmd.abort_req = 1'b0;
            end
            default:
            begin
                cmd.abort_req = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/hrfq_queue.sv
`default_nettype none

module hrfq_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  hrfq_pkg::cmd_t  push_cmd,
    output logic            full,
    input  wire             pop,
    output logic            head_valid,
    output hrfq_pkg::cmd_t  head_cmd
);
    import hrfq_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + QPTR_W'(1);
        return r;
    endfunction

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

FILE: rtl/core/hrfq_back.sv
`default_nettype none

module hrfq_back (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_valid,
    input  wire [hrfq_pkg::CFG_W-1:0]     cfg_data,
    input  wire                           head_valid,
    input  hrfq_pkg::cmd_t                head_cmd,
    output logic                          pop,
    output logic                          out_valid,
    input  wire                           out_stall,
    output hrfq_pkg::out_word_t           out_word
);
    import hrfq_pkg::*;

    logic [LIM_W-1:0]         limit_reg;
    rx_state_t                rx_mode_reg, rx_mode_next;
    logic [CNT_W-1:0]         byte_count_reg, byte_count_next;
    logic [COUNTER_WIDTH-1:0] crc_cnt_reg, crc_cnt_next;
    logic [COUNTER_WIDTH-1:0] ovr_cnt_reg, ovr_cnt_next;
    logic [COUNTER_WIDTH-1:0] ovs_cnt_reg, ovs_cnt_next;
    logic [COUNTER_WIDTH-1:0] abt_cnt_reg, abt_cnt_next;
    logic [COUNTER_WIDTH-1:0] end_cnt_reg, end_cnt_next;
    logic                     out_valid_reg, out_valid_next;
    out_word_t                out_word_reg, out_word_next;

    logic [LIM_W-1:0] cnt;
    logic [LIM_W-1:0] cfg_ext;
    logic [LIM_W-1:0] flen;
    logic             st_valid;
    logic [LIM_W-1:0] st_addr;
    logic             commit;
    logic             drop;

    // Take the queue head when the output register is free or being emptied.
    assign pop       = head_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cfg_ext   = LIM_W'(cfg_data);

    // Receive state machine and counters for one word.
    always_comb
    begin
        rx_mode_next = rx_mode_reg;
        cnt          = LIM_W'(byte_count_reg);
        crc_cnt_next = crc_cnt_reg;
        ovr_cnt_next = ovr_cnt_reg;
        ovs_cnt_next = ovs_cnt_reg;
        abt_cnt_next = abt_cnt_reg;
        end_cnt_next = end_cnt_reg;
        st_valid     = 1'b0;
        st_addr      = '0;
        commit       = 1'b0;
        flen         = '0;
        drop         = 1'b0;

        unique case (head_cmd.op)
            OP_RECEIVE:
            begin
                // A character either lands in the buffer or, when the receiver is not active, makes it active.
                if (head_cmd.has_char)
                begin
                    if (head_cmd.overrun)
                    begin
                        cnt          = '0;
                        rx_mode_next = RX_ERROR;
                        ovr_cnt_next = ovr_cnt_next + COUNTER_WIDTH'(1);
                    end
                    else if (cnt >= limit_reg)
                    begin
                        ovs_cnt_next = ovs_cnt_next + COUNTER_WIDTH'(1);
                        cnt          = '0;
                        rx_mode_next = RX_OVERSIZE;
                    end
                    if (rx_mode_next == RX_ACTIVE)
                    begin
                        st_valid = 1'b1;
                        st_addr  = cnt;
                        cnt      = cnt + LIM_W'(1);
                    end
                    else
                    begin
                        rx_mode_next = RX_ACTIVE;
                    end
                end
                // Closing flag: commit or drop a non-empty frame.
                if (head_cmd.eof)
                begin
                    end_cnt_next = end_cnt_next + COUNTER_WIDTH'(1);
                    if (cnt != '0)
                    begin
                        if (head_cmd.crc_bad || (rx_mode_next > RX_ACTIVE) ||
                            (cnt < MIN_FRAME))
                        begin
                            if (head_cmd.crc_bad)
                                crc_cnt_next = crc_cnt_next + COUNTER_WIDTH'(1);
                            if (rx_mode_next == RX_ERROR)
                                ovr_cnt_next = ovr_cnt_next + COUNTER_WIDTH'(1);
                            drop = 1'b1;
                        end
                        else
                        begin
                            commit = 1'b1;
                            flen   = cnt - CRC_BYTES;
                        end
                        cnt = '0;
                    end
                    rx_mode_next = RX_ACTIVE;
                end
            end
            OP_STATUS:
            begin
                if ((rx_mode_reg == RX_ACTIVE) && head_cmd.abort_req)
                begin
                    cnt          = '0;
                    abt_cnt_next = abt_cnt_reg + COUNTER_WIDTH'(1);
                end
            end
            OP_TX_MODE:
            begin
                rx_mode_next = RX_IDLE;
            end
            OP_RX_MODE:
            begin
                rx_mode_next = RX_ACTIVE;
            end
            default:
            begin
                rx_mode_next = rx_mode_reg;
            end
        endcase

        byte_count_next = CNT_W'(cnt);

        // Result word for this command.
        out_word_next.store_valid     = st_valid;
        out_word_next.store_address   = st_addr[ADDR_W-1:0];
        out_word_next.store_byte      = st_valid ? head_cmd.data_byte : 8'd0;
        out_word_next.frame_commit    = commit;
        out_word_next.frame_length    = flen[ADDR_W-1:0];
        out_word_next.frame_drop      = drop;
        out_word_next.crc_error_total = TOTAL_W'(crc_cnt_next);
        out_word_next.overrun_total   = TOTAL_W'(ovr_cnt_next);
        out_word_next.oversize_total  = TOTAL_W'(ovs_cnt_next);
        out_word_next.abort_total     = TOTAL_W'(abt_cnt_next);
        out_word_next.end_total       = TOTAL_W'(end_cnt_next);
        out_word_next.receive_state   = STATE_W'(rx_mode_next);

        out_valid_next = pop || (out_valid_reg && out_stall);
    end

    // Control state: receive state and counters update only when a word is taken, the limit on a register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= LIM_RESET;
            rx_mode_reg    <= RX_ACTIVE;
            byte_count_reg <= '0;
            crc_cnt_reg    <= '0;
            ovr_cnt_reg    <= '0;
            ovs_cnt_reg    <= '0;
            abt_cnt_reg    <= '0;
            end_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                limit_reg <= (cfg_ext < DEPTH_LIM) ? cfg_ext : DEPTH_LIM;
            if (pop)
            begin
                rx_mode_reg    <= rx_mode_next;
                byte_count_reg <= byte_count_next;
                crc_cnt_reg    <= crc_cnt_next;
                ovr_cnt_reg    <= ovr_cnt_next;
                ovs_cnt_reg    <= ovs_cnt_next;
                abt_cnt_reg    <= abt_cnt_next;
                end_cnt_reg    <= end_cnt_next;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (pop)
            out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/hdlc_rx_frame_qualifier.sv
`default_nettype none

// HDLC receive frame qualifier. Each input word is one event from the serial
// controller (receive character, external status, or a mode switch) and yields
// exactly one output word: the buffer write for a good byte, the commit or
// drop decision at end of frame, the running error counters and the receive
// state after the event. The block accepts one word per clock cycle while the
// queue has room; a two-word command queue separates the input decode from the
// state update, so the output side can stall without holding off the input
// until the queue fills. An accepted word is written into the queue and then
// moved into the output register when that register is free or being emptied.
// The buffer size register may be written at any
// time the block is idle and takes effect on the next event.

module hdlc_rx_frame_qualifier (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  hrfq_pkg::in_word_t         in_word,
    output logic                       out_valid,
    input  wire                        out_stall,
    output hrfq_pkg::out_word_t        out_word,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire [hrfq_pkg::CFG_W-1:0]  cfg_data
);
    import hrfq_pkg::*;

    logic push;
    logic pop;
    logic queue_full;
    logic head_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // The register write is always taken.
    assign cfg_ready = 1'b1;

    hrfq_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .push       (push),
        .cmd        (push_cmd),
        .queue_full (queue_full)
    );

    hrfq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    hrfq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule

`default_nettype wire

FILE: bench/hdlc_rx_frame_qualifier_tb.sv
`default_nettype none

module hdlc_rx_frame_qualifier_tb;

    import hrfq_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 125;
    localparam int RANDOM_ITEMS = 1250;
    localparam int SETTLE       = 4;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_word_t             in_word = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_word_t            out_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Words waiting to be sent and outcomes waiting to be seen.
    in_word_t  event_queue[$];
    out_word_t predicted_outcomes[$];

    int mismatches = 0;
    int cycle_count = 0;

    // Qualifier state as the bench tracks it.
    int              buf_size;
    rx_state_t       rx_state;
    int              frame_bytes;
    logic [15:0]     crc_err_cnt;
    logic [15:0]     overrun_cnt;
    logic [15:0]     oversize_cnt;
    logic [15:0]     abort_cnt;
    logic [15:0]     end_cnt;

    // Sender burst shaping.
    int gap_left;
    int burst_left;
    int steady;

    // Receiver stall pattern.
    int stall_mode;
    int stall_tick;

    hdlc_rx_frame_qualifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Works out the outcome of one controller event and advances the state.
    function automatic out_word_t qualify_event(in_word_t w);
        out_word_t r;
        int        lim;
        r = '0;
        lim = (buf_size < BUF_DEPTH) ? buf_size : BUF_DEPTH;
        case (op_t'(w.operation))
            OP_RECEIVE:
            begin
                if (w.char_available)
                begin
                    if (w.overrun)
                    begin
                        frame_bytes = 0;
                        rx_state = RX_ERROR;
                        overrun_cnt = overrun_cnt + 16'd1;
                    end
                    else if (frame_bytes >= lim)
                    begin
                        oversize_cnt = oversize_cnt + 16'd1;
                        frame_bytes = 0;
                        rx_state = RX_OVERSIZE;
                    end
                    // Only an active receiver stores; otherwise the byte clears the state.
                    if (rx_state == RX_ACTIVE)
                    begin
                        r.store_valid = 1'b1;
                        r.store_address = ADDR_W'(frame_bytes);
                        r.store_byte = w.data_byte;
                        frame_bytes = (frame_bytes + 1) & 32'h1FFF;
                    end
                    else
                    begin
                        rx_state = RX_ACTIVE;
                    end
                end
                if (w.end_of_frame)
                begin
                    end_cnt = end_cnt + 16'd1;
                    if (frame_bytes > 0)
                    begin
                        if (w.crc_bad || rx_state > RX_ACTIVE || frame_bytes < int'(MIN_FRAME))
                        begin
                            if (w.crc_bad)
                                crc_err_cnt = crc_err_cnt + 16'd1;
                            if (rx_state == RX_ERROR)
                                overrun_cnt = overrun_cnt + 16'd1;
                            r.frame_drop = 1'b1;
                        end
                        else
                        begin
                            r.frame_commit = 1'b1;
                            r.frame_length = ADDR_W'(frame_bytes - int'(CRC_BYTES));
                        end
                        frame_bytes = 0;
                    end
                    rx_state = RX_ACTIVE;
                end
            end
            OP_STATUS:
            begin
                if (rx_state == RX_ACTIVE && w.abort_seen)
                begin
                    frame_bytes = 0;
                    abort_cnt = abort_cnt + 16'd1;
                end
            end
            OP_TX_MODE:
                rx_state = RX_IDLE;
            default:
                rx_state = RX_ACTIVE;
        endcase
        r.crc_error_total = crc_err_cnt;
        r.overrun_total = overrun_cnt;
        r.oversize_total = oversize_cnt;
        r.abort_total = abort_cnt;
        r.end_total = end_cnt;
        r.receive_state = rx_state;
        return r;
    endfunction

    function automatic in_word_t ev(op_t op, bit chr, bit ovr, logic [7:0] data,
                                    bit eof, bit crc, bit abrt);
        in_word_t w;
        w.operation = op;
        w.char_available = chr;
        w.overrun = ovr;
        w.data_byte = data;
        w.end_of_frame = eof;
        w.crc_bad = crc;
        w.abort_seen = abrt;
        return w;
    endfunction

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // Driver: presents queued words in bursts and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word <= '0;
            gap_left = 0;
            burst_left = 8;
            steady = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predicted_outcomes.push_back(qualify_event(in_word));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (event_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_word <= event_queue.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        if ($urandom_range(0, 5) == 0)
                            steady = !steady;
                        gap_left = steady ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted word and drives the stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        logic      stall_next;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode = 0;
            stall_tick = 100;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_outcomes.size() == 0)
                begin
                    $display("%0t: word %h with none expected", $time, out_word);
                    mismatches++;
                end
                else
                begin
                    want = predicted_outcomes.pop_front();
                    check_field("store_valid", want.store_valid, out_word.store_valid);
                    check_field("store_address", want.store_address, out_word.store_address);
                    check_field("store_byte", want.store_byte, out_word.store_byte);
                    check_field("frame_commit", want.frame_commit, out_word.frame_commit);
                    check_field("frame_length", want.frame_length, out_word.frame_length);
                    check_field("frame_drop", want.frame_drop, out_word.frame_drop);
                    check_field("crc_error_total", want.crc_error_total,
                                out_word.crc_error_total);
                    check_field("overrun_total", want.overrun_total, out_word.overrun_total);
                    check_field("oversize_total", want.oversize_total,
                                out_word.oversize_total);
                    check_field("abort_total", want.abort_total, out_word.abort_total);
                    check_field("end_total", want.end_total, out_word.end_total);
                    check_field("receive_state", want.receive_state, out_word.receive_state);
                end
            end
            if (stall_tick == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_tick = $urandom_range(50, 300);
            end
            else
            begin
                stall_tick--;
            end
            case (stall_mode)
                0:       stall_next = 1'b0;
                1:       stall_next = ($urandom_range(0, 3) == 0);
                2:       stall_next = ($urandom_range(0, 9) < 6);
                default: stall_next = ((stall_tick % 3) == 0);
            endcase
            out_stall <= stall_next;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hdlc_rx_frame_qualifier: mismatch");
            $finish;
        end
    end

    // Holds the sender until every word has been sent and every outcome seen.
    task automatic drain();
        while (event_queue.size() > 0 || in_valid || predicted_outcomes.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_buffer_size(int value);
        drain();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        buf_size = value;
        @(negedge clk);
    endtask

    // One frame with random content and occasional overruns and aborts, ended in-line or by a flag event.
    task automatic push_frame(int len);
        bit inline_end;
        bit crc;
        inline_end = $urandom_range(0, 1);
        crc = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 59) == 0)
                event_queue.push_back(ev(OP_STATUS, $urandom_range(0, 1), $urandom_range(0, 1),
                                         $urandom_range(0, 255), 0, 0, 1));
            event_queue.push_back(ev(OP_RECEIVE, 1, ($urandom_range(0, 39) == 0),
                                     $urandom_range(0, 255),
                                     inline_end && (i == len - 1), crc, $urandom_range(0, 1)));
        end
        if (!inline_end)
            event_queue.push_back(ev(OP_RECEIVE, 0, 0, $urandom_range(0, 255), 1, crc,
                                     $urandom_range(0, 1)));
    endtask

    initial
    begin
        int lim;
        int pick;
        int size_val;
        buf_size = 4096;
        rx_state = RX_ACTIVE;
        frame_bytes = 0;
        crc_err_cnt = '0;
        overrun_cnt = '0;
        oversize_cnt = '0;
        abort_cnt = '0;
        end_cnt = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at the reset buffer size.
        event_queue.push_back(ev(OP_RX_MODE, 1, 1, 8'hFF, 1, 1, 1));
        for (int i = 0; i < 12; i++)
            event_queue.push_back(ev(OP_RECEIVE, 1, 0,
                                     (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'(i * 37),
                                     i == 11, 0, 0));
        // End flag with nothing received.
        event_queue.push_back(ev(OP_RECEIVE, 0, 0, 8'h00, 1, 1, 0));
        // Short frame with a CRC error.
        event_queue.push_back(ev(OP_RECEIVE, 1, 0, 8'h11, 0, 0, 0));
        event_queue.push_back(ev(OP_RECEIVE, 1, 0, 8'h22, 1, 1, 0));
        // Overrun alone, then overrun together with end of frame.
        event_queue.push_back(ev(OP_RECEIVE, 1, 1, 8'h5A, 0, 0, 0));
        event_queue.push_back(ev(OP_RECEIVE, 1, 1, 8'hA5, 1, 0, 0));
        // Abort of an active frame.
        event_queue.push_back(ev(OP_RECEIVE, 1, 0, 8'h33, 0, 0, 0));
        event_queue.push_back(ev(OP_RECEIVE, 1, 0, 8'h44, 0, 0, 0));
        event_queue.push_back(ev(OP_STATUS, 0, 0, 8'h00, 0, 0, 1));
        // Transmit mode: abort ignored, the first character is discarded.
        event_queue.push_back(ev(OP_TX_MODE, 1, 1, 8'hFF, 1, 1, 1));
        event_queue.push_back(ev(OP_STATUS, 1, 1, 8'hFF, 1, 1, 1));
        event_queue.push_back(ev(OP_RECEIVE, 1, 0, 8'h77, 0, 0, 0));
        event_queue.push_back(ev(OP_STATUS, 1, 1, 8'hFF, 1, 1, 0));

        // Random phases, each at its own buffer size.
        for (int phase = 0; phase * PHASE_ITEMS < RANDOM_ITEMS; phase++)
        begin
            case (phase % 8)
                0:       size_val = 1;
                1:       size_val = 0;
                2:       size_val = 12;
                3:       size_val = 8191;
                4:       size_val = 10;
                5:       size_val = 4096;
                6:       size_val = 11;
                default: size_val = $urandom_range(2, 40);
            endcase
            write_buffer_size(size_val);
            lim = (size_val < BUF_DEPTH) ? size_val : BUF_DEPTH;
            while (event_queue.size() < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    push_frame($urandom_range(1, (lim < 40) ? lim + 3 : 40));
                end
                else if (pick < 85)
                begin
                    event_queue.push_back(ev(OP_STATUS, $urandom_range(0, 1),
                                             $urandom_range(0, 1), $urandom_range(0, 255),
                                             $urandom_range(0, 1), $urandom_range(0, 1),
                                             $urandom_range(0, 1)));
                end
                else if (pick < 92)
                begin
                    event_queue.push_back(ev($urandom_range(0, 1) ? OP_TX_MODE : OP_RX_MODE,
                                             $urandom_range(0, 1), $urandom_range(0, 1),
                                             $urandom_range(0, 255), $urandom_range(0, 1),
                                             $urandom_range(0, 1), $urandom_range(0, 1)));
                end
                else
                begin
                    event_queue.push_back(ev(op_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                                             $urandom_range(0, 1), $urandom_range(0, 255),
                                             $urandom_range(0, 1), $urandom_range(0, 1),
                                             $urandom_range(0, 1)));
                end
            end
        end

        drain();
        if (mismatches == 0)
            $display("hdlc_rx_frame_qualifier: match");
        else
            $display("hdlc_rx_frame_qualifier: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

FILE: hdlc_rx_frame_qualifier.f
rtl/core/hrfq_pkg.sv
rtl/core/hrfq_front.sv
rtl/core/hrfq_queue.sv
rtl/core/hrfq_back.sv
rtl/core/hdlc_rx_frame_qualifier.sv
bench/hdlc_rx_frame_qualifier_tb.sv
